### hw/rtl/spdmed_pkg.sv
// shared constants for the speed estimate median filter
package spdmed_pkg;

	// default number of raw speeds held in the median window
	localparam int WINDOW_DEF = 11;

	// field widths
	localparam int POS_W   = 32;
	localparam int SPEED_W = 32;
	localparam int SCALE_W = 16;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index of rate_scale
	localparam logic REG_RATE_SCALE = 1'b0;

	// rate_scale after reset: 20 per second in Q8.8
	localparam logic [SCALE_W-1:0] RATE_SCALE_RST = 16'd5120;

endpackage

### hw/rtl/speed_estimate_median_filter.sv
// speed estimate median filter: position difference, rate scaling and window median
//
// Takes one signed Q15.16 position per input beat and returns, one output beat per
// input beat and in order, the scaled absolute position difference (raw speed,
// unsigned Q16.16, saturated) and the median of the last WINDOW raw speeds. The
// window and the previous position start at zero after reset. The block takes one
// beat every clock cycle unless a stalled output has filled every stage. Each beat
// passes to the output through a pipeline of difference, multiply, window write,
// rank compare and rank select stages. Each stage holds its beat while the next one
// is full and held, so a stalled output only stops the input once every stage is
// occupied. rate_scale sits at byte address 0 of the configuration port and is
// meant to be written while no beat is in flight.
module speed_estimate_median_filter #(
	parameter int WINDOW = spdmed_pkg::WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [spdmed_pkg::POS_W-1:0]      s_tdata,   // [31:0] position_sample
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [2*spdmed_pkg::SPEED_W-1:0]  m_tdata,   // [31:0] raw_speed, [63:32] median_speed
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [spdmed_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [spdmed_pkg::APB_DATA_W-1:0] pwdata,
	output logic [spdmed_pkg::APB_DATA_W-1:0] prdata,
	output logic                              pready
);

	localparam int SW     = spdmed_pkg::SPEED_W;
	localparam int PW     = spdmed_pkg::POS_W;
	localparam int KW     = spdmed_pkg::SCALE_W;
	localparam int PROD_W = SW + KW;
	localparam int IDX_W  = $clog2(WINDOW);
	localparam int TARGET = (WINDOW - 1) / 2;
	localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(WINDOW - 1);
	localparam logic [IDX_W-1:0] TARGET_IDX = IDX_W'(TARGET);

	// configuration register
	logic [KW-1:0] rate_scale_q;

	// pipeline valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic mv_s1, mv_s2, mv_s3, mv_s4, mv_s5;

	// state
	logic [PW-1:0]    prev_pos_q;
	logic [SW-1:0]    win_q [WINDOW];
	logic [IDX_W-1:0] slot_q;

	// pipeline payload
	logic [SW-1:0]     diff_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [SW-1:0]     raw_s3, raw_s4, raw_s5;
	logic [SW-1:0]     win_s3 [WINDOW];
	logic [SW-1:0]     val_s4 [WINDOW];
	logic [WINDOW-1:0] below_s4 [WINDOW];
	logic [SW-1:0]     med_s5;

	// combinational values
	logic [PW:0]       dif_a, dif_b;
	logic [SW-1:0]     abs_diff;
	logic [SW-1:0]     raw_speed;
	logic [SW-1:0]     win_next [WINDOW];
	logic [WINDOW-1:0] below_next [WINDOW];
	logic [SW-1:0]     med_next;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_scale_q <= spdmed_pkg::RATE_SCALE_RST;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == spdmed_pkg::REG_RATE_SCALE) begin
			rate_scale_q <= pwdata[KW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == spdmed_pkg::REG_RATE_SCALE) begin
			prdata = {{(spdmed_pkg::APB_DATA_W-KW){1'b0}}, rate_scale_q};
		end
	end

	// stage handshake: a stage takes a beat when empty or when its beat moves on
	assign rdy_s5 = !v_s5 || m_tready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign s_tready = rdy_s1;
	assign mv_s1 = s_tvalid && rdy_s1;
	assign mv_s2 = v_s1 && rdy_s2;
	assign mv_s3 = v_s2 && rdy_s3;
	assign mv_s4 = v_s3 && rdy_s4;
	assign mv_s5 = v_s4 && rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// absolute position difference, both signs computed side by side
	assign dif_a = {s_tdata[PW-1], s_tdata} - {prev_pos_q[PW-1], prev_pos_q};
	assign dif_b = {prev_pos_q[PW-1], prev_pos_q} - {s_tdata[PW-1], s_tdata};
	assign abs_diff = dif_a[PW] ? dif_b[SW-1:0] : dif_a[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q <= '0;
		end else if (mv_s1) begin
			prev_pos_q <= s_tdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s1) diff_s1 <= abs_diff;
	end

	// rate scaling
	always_ff @(posedge clk) begin
		if (mv_s2) prod_s2 <= PROD_W'(diff_s1) * PROD_W'(rate_scale_q);
	end

	// drop the eight fraction bits and saturate
	assign raw_speed = (prod_s2[PROD_W-1:SW+8] != '0) ? '1 : prod_s2[SW+7:8];

	// window with the new raw speed in the current slot
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			win_next[i] = (slot_q == IDX_W'(i)) ? raw_speed : win_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= '0;
			end
		end else if (mv_s3) begin
			slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= win_next[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s3) begin
			raw_s3 <= raw_speed;
			for (int i = 0; i < WINDOW; i++) begin
				win_s3[i] <= win_next[i];
			end
		end
	end

	// rank compare matrix, ties ordered by slot
	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			for (int j = 0; j < WINDOW; j++) begin
				below_next[i][j] = (win_s3[j] < win_s3[i]) ||
					((win_s3[j] == win_s3[i]) && (j < i));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s4) begin
			raw_s4 <= raw_s3;
			for (int i = 0; i < WINDOW; i++) begin
				val_s4[i]   <= win_s3[i];
				below_s4[i] <= below_next[i];
			end
		end
	end

	// pick the entry whose rank is the middle one
	always_comb begin
		logic [IDX_W-1:0] rank;
		med_next = '0;
		for (int i = 0; i < WINDOW; i++) begin
			rank = '0;
			for (int j = 0; j < WINDOW; j++) begin
				rank = rank + IDX_W'(below_s4[i][j]);
			end
			if (rank == TARGET_IDX) begin
				med_next = med_next | val_s4[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (mv_s5) begin
			raw_s5 <= raw_s4;
			med_s5 <= med_next;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {med_s5, raw_s5};

endmodule
